[rtl/sstoi_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Swept sphere time of impact: shared package
// Field widths, derived datapath widths and the item types of both channels.
// ----------------------------------------------------------------------------
package sstoi_pkg;

  // Field widths of the channels.
  localparam int CoordWidth   = 32;
  localparam int TimeFracBits = 16;

  // Limb width of the pipelined multipliers.
  localparam int MulLimb = 32;

  // Derived datapath widths.
  localparam int AccWidth   = 2 * CoordWidth + 2;  // a, m.m, half b sums
  localparam int BWidth     = 2 * CoordWidth + 3;  // |b|
  localparam int DiscWidth  = 2 * BWidth;          // b^2, 4ac, discriminant
  localparam int RootWidth  = BWidth;              // floor square root
  localparam int SqRemWidth = RootWidth + 4;       // square root remainder
  localparam int DenWidth   = AccWidth + 1;        // 2a
  localparam int DivWidth   = DenWidth + 1;        // divider remainder
  localparam int TimeWidth  = TimeFracBits + 1;

  // Register stages from input to output register.
  localparam int Stages = 14 + RootWidth + TimeWidth;

  typedef struct packed {
    logic signed [CoordWidth-1:0] start_x;
    logic signed [CoordWidth-1:0] start_y;
    logic signed [CoordWidth-1:0] start_z;
    logic signed [CoordWidth-1:0] end_x;
    logic signed [CoordWidth-1:0] end_y;
    logic signed [CoordWidth-1:0] end_z;
    logic        [CoordWidth-2:0] moving_radius;
    logic signed [CoordWidth-1:0] target_x;
    logic signed [CoordWidth-1:0] target_y;
    logic signed [CoordWidth-1:0] target_z;
    logic        [CoordWidth-2:0] target_radius;
  } query_t;

  typedef struct packed {
    logic                 hit;
    logic [TimeWidth-1:0] impact_time;
  } result_t;

endpackage

[rtl/sstoi_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Swept sphere time of impact: pipelined unsigned multiplier
// Splits both operands into limbs, registers the limb products, then the row
// sums, then the full product, each register advancing only when enabled.
// ----------------------------------------------------------------------------
module sstoi_mul #(
  parameter int XW = 32,
  parameter int YW = 32,
  parameter int LW = 32
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [XW-1:0]   x_i,
  input  logic [YW-1:0]   y_i,
  output logic [XW+YW-1:0] p_o
);
  import sstoi_pkg::*;

  localparam int NX = (XW + LW - 1) / LW;
  localparam int NY = (YW + LW - 1) / LW;
  localparam int PW = XW + YW;

  logic [NX*LW-1:0] xe;
  logic [NY*LW-1:0] ye;
  logic [2*LW-1:0]  pp_q [NX][NY];
  logic [PW-1:0]    row_d [NX];
  logic [PW-1:0]    row_q [NX];
  logic [PW-1:0]    sum_d;
  logic [PW-1:0]    p_q;

  assign xe = (NX*LW)'(x_i);
  assign ye = (NY*LW)'(y_i);

  // Limb products, one narrow multiplier each.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NX; i++) begin
        for (int j = 0; j < NY; j++) begin
          pp_q[i][j] <= xe[i*LW +: LW] * ye[j*LW +: LW];
        end
      end
    end
  end

  // Sum each row of limb products.
  always_comb begin
    for (int i = 0; i < NX; i++) begin
      row_d[i] = '0;
      for (int j = 0; j < NY; j++) begin
        row_d[i] = row_d[i] + (PW'(pp_q[i][j]) << (j * LW));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      row_q <= row_d;
    end
  end

  // Sum the rows into the full product.
  always_comb begin
    sum_d = '0;
    for (int i = 0; i < NX; i++) begin
      sum_d = sum_d + (row_q[i] << (i * LW));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= sum_d;
    end
  end

  assign p_o = p_q;

endmodule

[rtl/swept_sphere_time_of_impact.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Swept sphere time of impact
// Earliest contact time of a moving sphere against a stationary sphere.
// ----------------------------------------------------------------------------
// The block accepts one query per cycle while the output is not stalled and
// returns exactly one result per query, in order. Most of the pipeline depth
// is the square root, which retires one root bit per stage, followed by the
// divider, which retires one time bit per stage. The whole pipeline advances
// together: while a result waits on a stalled output, every stage holds and
// the input is stalled. A hit is reported only when the spheres are apart at
// the start, the sphere moves, the discriminant is not negative and the
// earliest root lies in [0, 1]; otherwise hit and impact_time are both zero.
// ----------------------------------------------------------------------------
module swept_sphere_time_of_impact (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sstoi_pkg::query_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sstoi_pkg::result_t out_data_o
);
  import sstoi_pkg::*;

  localparam int CW = CoordWidth;

  typedef struct packed {
    logic [SqRemWidth-1:0] rem;
    logic [RootWidth-1:0]  root;
    logic [DiscWidth-1:0]  rad;
    logic [BWidth-1:0]     bmag;
    logic [DenWidth-1:0]   den;
    logic                  nohit;
  } sq_t;

  typedef struct packed {
    logic [DivWidth-1:0]  r;
    logic [TimeWidth-1:0] q;
    logic [DenWidth-1:0]  den;
    logic                 nohit;
  } dv_t;

  // Global advance: everything moves unless a result is stuck at the output.
  logic              en;
  logic [Stages-1:0] vld_q;

  assign en         = !(vld_q[Stages-1] && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Stages-2:0], in_valid_i};
    end
  end

  // Stage one: center differences and radius sum.
  logic [CW-1:0] st [3];
  logic [CW-1:0] fin [3];
  logic [CW-1:0] tg [3];
  logic [CW:0]   d_d [3];
  logic [CW:0]   m_d [3];
  logic [CW:0]   d_q [3];
  logic [CW:0]   m_q [3];
  logic [CW-1:0] s_d;
  logic [CW-1:0] s_q;

  always_comb begin
    st[0]  = in_data_i.start_x;
    st[1]  = in_data_i.start_y;
    st[2]  = in_data_i.start_z;
    fin[0] = in_data_i.end_x;
    fin[1] = in_data_i.end_y;
    fin[2] = in_data_i.end_z;
    tg[0]  = in_data_i.target_x;
    tg[1]  = in_data_i.target_y;
    tg[2]  = in_data_i.target_z;
    for (int i = 0; i < 3; i++) begin
      d_d[i] = {fin[i][CW-1], fin[i]} - {st[i][CW-1], st[i]};
      m_d[i] = {st[i][CW-1], st[i]} - {tg[i][CW-1], tg[i]};
    end
    s_d = CW'(in_data_i.moving_radius) + CW'(in_data_i.target_radius);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_q <= d_d;
      m_q <= m_d;
      s_q <= s_d;
    end
  end

  // Stage two: magnitudes and whether the signs of m and d differ.
  logic [CW:0]   dn [3];
  logic [CW:0]   mn [3];
  logic [CW-1:0] dm_q [3];
  logic [CW-1:0] mm_mag_q [3];
  logic [2:0]    xs_q;
  logic [CW-1:0] s2_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dn[i] = d_q[i][CW] ? (~d_q[i] + 1'b1) : d_q[i];
      mn[i] = m_q[i][CW] ? (~m_q[i] + 1'b1) : m_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dm_q[i]     <= dn[i][CW-1:0];
        mm_mag_q[i] <= mn[i][CW-1:0];
        xs_q[i]     <= m_q[i][CW] != d_q[i][CW];
      end
      s2_q <= s_q;
    end
  end

  // First multiplier bank: d.d, m.m and m.d terms, and s^2.
  logic [2*CW-1:0] dd_p [3];
  logic [2*CW-1:0] mm_p [3];
  logic [2*CW-1:0] md_p [3];
  logic [2*CW-1:0] rr_p;
  logic [2:0]      xs_dly_q [3];

  for (genvar i = 0; i < 3; i++) begin : g_mul1
    sstoi_mul #(.XW(CW), .YW(CW), .LW(MulLimb)) u_dd (
      .clk_i(clk_i), .en_i(en), .x_i(dm_q[i]), .y_i(dm_q[i]), .p_o(dd_p[i])
    );
    sstoi_mul #(.XW(CW), .YW(CW), .LW(MulLimb)) u_mm (
      .clk_i(clk_i), .en_i(en), .x_i(mm_mag_q[i]), .y_i(mm_mag_q[i]), .p_o(mm_p[i])
    );
    sstoi_mul #(.XW(CW), .YW(CW), .LW(MulLimb)) u_md (
      .clk_i(clk_i), .en_i(en), .x_i(mm_mag_q[i]), .y_i(dm_q[i]), .p_o(md_p[i])
    );
  end

  sstoi_mul #(.XW(CW), .YW(CW), .LW(MulLimb)) u_rr (
    .clk_i(clk_i), .en_i(en), .x_i(s2_q), .y_i(s2_q), .p_o(rr_p)
  );

  // Sign flags ride along with the multiplier bank.
  always_ff @(posedge clk_i) begin
    if (en) begin
      xs_dly_q[0] <= xs_q;
      xs_dly_q[1] <= xs_dly_q[0];
      xs_dly_q[2] <= xs_dly_q[1];
    end
  end

  // Stage six: dot product sums; m.d split by the sign of each term.
  logic [AccWidth-1:0] a_d, mm_d, hp_d, hn_d;
  logic [AccWidth-1:0] a_q, mm_q, hp_q, hn_q;
  logic [2*CW-1:0]     rr_q;

  always_comb begin
    a_d  = '0;
    mm_d = '0;
    hp_d = '0;
    hn_d = '0;
    for (int i = 0; i < 3; i++) begin
      a_d  = a_d + AccWidth'(dd_p[i]);
      mm_d = mm_d + AccWidth'(mm_p[i]);
      if (xs_dly_q[2][i]) begin
        hn_d = hn_d + AccWidth'(md_p[i]);
      end else begin
        hp_d = hp_d + AccWidth'(md_p[i]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q  <= a_d;
      mm_q <= mm_d;
      hp_q <= hp_d;
      hn_q <= hn_d;
      rr_q <= rr_p;
    end
  end

  // Stage seven: early rejects, c, |b| and 2a.
  logic                nohit7_q;
  logic [AccWidth-1:0] a7_q, c7_q;
  logic [BWidth-1:0]   b7_q;
  logic [DenWidth-1:0] den7_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      nohit7_q <= (mm_q <= AccWidth'(rr_q)) || (a_q == '0) || !(hn_q > hp_q);
      a7_q     <= a_q;
      c7_q     <= mm_q - AccWidth'(rr_q);
      b7_q     <= {BWidth'(hn_q - hp_q)} << 1;
      den7_q   <= {1'b0, a_q} << 1;
    end
  end

  // Second multiplier bank: b^2 and a*c.
  logic [DiscWidth-1:0]  b2_p;
  logic [2*AccWidth-1:0] ac_p;
  logic                  nohit_dly_q [3];
  logic [BWidth-1:0]     b_dly_q [3];
  logic [DenWidth-1:0]   den_dly_q [3];

  sstoi_mul #(.XW(BWidth), .YW(BWidth), .LW(MulLimb)) u_b2 (
    .clk_i(clk_i), .en_i(en), .x_i(b7_q), .y_i(b7_q), .p_o(b2_p)
  );
  sstoi_mul #(.XW(AccWidth), .YW(AccWidth), .LW(MulLimb)) u_ac (
    .clk_i(clk_i), .en_i(en), .x_i(a7_q), .y_i(c7_q), .p_o(ac_p)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      nohit_dly_q[0] <= nohit7_q;
      b_dly_q[0]     <= b7_q;
      den_dly_q[0]   <= den7_q;
      for (int i = 1; i < 3; i++) begin
        nohit_dly_q[i] <= nohit_dly_q[i-1];
        b_dly_q[i]     <= b_dly_q[i-1];
        den_dly_q[i]   <= den_dly_q[i-1];
      end
    end
  end

  // Stage eleven: discriminant, then the square root pipeline.
  logic [DiscWidth-1:0] ac4;
  sq_t                  sq_q [RootWidth+1];
  sq_t                  sq_d [RootWidth+1];

  assign ac4 = DiscWidth'(ac_p) << 2;

  always_comb begin
    sq_d[0].rem   = '0;
    sq_d[0].root  = '0;
    sq_d[0].rad   = b2_p - ac4;
    sq_d[0].bmag  = b_dly_q[2];
    sq_d[0].den   = den_dly_q[2];
    sq_d[0].nohit = nohit_dly_q[2] || (b2_p < ac4);
  end

  // One root bit per stage, restoring digit by digit.
  for (genvar k = 1; k <= RootWidth; k++) begin : g_sqrt
    logic [SqRemWidth-1:0] cur, trial;
    logic                  ge;

    always_comb begin
      cur   = {sq_q[k-1].rem[SqRemWidth-3:0], sq_q[k-1].rad[DiscWidth-1 -: 2]};
      trial = SqRemWidth'({sq_q[k-1].root, 2'b01});
      ge    = cur >= trial;
      sq_d[k]       = sq_q[k-1];
      sq_d[k].rem   = ge ? (cur - trial) : cur;
      sq_d[k].root  = {sq_q[k-1].root[RootWidth-2:0], ge};
      sq_d[k].rad   = sq_q[k-1].rad << 2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_q <= sq_d;
    end
  end

  // Root must not lie before the step: numerator -b - sqrt.
  logic                nohit_e_q;
  logic [BWidth-1:0]   num_q;
  logic [DenWidth-1:0] den_e_q;
  dv_t                 dv_q [TimeWidth+1];
  dv_t                 dv_d [TimeWidth+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      nohit_e_q <= sq_q[RootWidth].nohit || (sq_q[RootWidth].bmag < sq_q[RootWidth].root);
      num_q     <= sq_q[RootWidth].bmag - sq_q[RootWidth].root;
      den_e_q   <= sq_q[RootWidth].den;
    end
  end

  // Root must not lie after the step; load the divider.
  always_comb begin
    dv_d[0].r     = DivWidth'(num_q);
    dv_d[0].q     = '0;
    dv_d[0].den   = den_e_q;
    dv_d[0].nohit = nohit_e_q || (DenWidth'(num_q) > den_e_q);
  end

  // One time bit per stage, restoring division of num * 2^F by 2a.
  for (genvar k = 1; k <= TimeWidth; k++) begin : g_div
    logic [DivWidth-1:0] rn;
    logic                ge;

    always_comb begin
      ge = dv_q[k-1].r >= DivWidth'(dv_q[k-1].den);
      rn = ge ? (dv_q[k-1].r - DivWidth'(dv_q[k-1].den)) : dv_q[k-1].r;
      dv_d[k]   = dv_q[k-1];
      dv_d[k].r = rn << 1;
      dv_d[k].q = {dv_q[k-1].q[TimeWidth-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_q <= dv_d;
    end
  end

  // Output register.
  result_t out_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.hit         <= !dv_q[TimeWidth].nohit;
      out_q.impact_time <= dv_q[TimeWidth].nohit ? '0 : dv_q[TimeWidth].q;
    end
  end

  assign out_valid_o = vld_q[Stages-1];
  assign out_data_o  = out_q;

  // A result stuck at the output holds back the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input taken while output stalled");

  // The pipeline occupancy freezes while stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(vld_q))
    else $error("pipeline moved during stall");

  // A hit never lies beyond the end of the step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.hit |->
      out_data_o.impact_time <= (TimeWidth'(1) << TimeFracBits))
    else $error("impact time beyond one");

  // A miss reports zero time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.hit |-> out_data_o.impact_time == '0)
    else $error("miss with nonzero time");

endmodule
